// ----- hdl/ntcmon_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants of the ntc average over-temperature monitor
// used by ntcmon_csr, ntcmon_ctrl, ntcmon_dpath and the top level
package ntcmon_pkg;

   localparam int SAMPLE_WIDTH = 16;
   localparam int DATA_WIDTH   = 16;
   localparam int CSR_IDX_W    = 3;
   localparam int REQ_TDATA_W  = 16;
   localparam int RSP_TDATA_W  = 40;
   localparam int DIV_STEPS    = DATA_WIDTH;
   localparam int DIV_CNT_W    = $clog2(DIV_STEPS);
   localparam int MUL_W        = DATA_WIDTH + 2;
   localparam int PROD_W       = 2 * MUL_W;
   localparam int SCALE_SHIFT  = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FILTER_LENGTH     = 3'd0,
      REG_OVER_THRESHOLD    = 3'd1,
      REG_RELEASE_THRESHOLD = 3'd2,
      REG_VIRTUAL_MODE      = 3'd3,
      REG_EXPECTED_CELSIUS  = 3'd4,
      REG_DIGITAL_OFFSET    = 3'd5,
      REG_SENSITIVITY       = 3'd6,
      REG_CELSIUS_OFFSET    = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0]        filter_length;
      logic [DATA_WIDTH-1:0]        over_threshold;
      logic [DATA_WIDTH-1:0]        release_threshold;
      logic                         virtual_mode;
      logic signed [DATA_WIDTH-1:0] expected_celsius;
      logic [DATA_WIDTH-1:0]        digital_offset;
      logic signed [DATA_WIDTH-1:0] sensitivity;
      logic signed [DATA_WIDTH-1:0] celsius_offset;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACC,
      ST_DIV,
      ST_EVAL,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic capture;     // latch the sample of the accepted beat
      logic clear_fault; // virtual mode forces the flag low
      logic mul_acc;     // product <= (n-1) * average
      logic load_div;    // dividend <= product + sample
      logic div_step;    // one restoring divide step
      logic eval;        // fault update and celsius product
      logic load_out;    // move the result into the output register
   } cmd_type;

   typedef struct packed {
      logic virtual_mode;
      logic sample_invalid;
      logic div_last;
      logic out_free;
   } sts_type;

endpackage

// ----- hdl/ntcmon_csr.sv -----
`timescale 1ns / 1ps
// configuration register file of the monitor, one write beat per register
// depends on ntcmon_pkg
module ntcmon_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ntcmon_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ntcmon_pkg::DATA_WIDTH-1:0]   csr_data,
   output ntcmon_pkg::cfg_type                 cfg
);

   ntcmon_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (ntcmon_pkg::csr_index_type'(csr_index))
            ntcmon_pkg::REG_FILTER_LENGTH:     cfg_in.filter_length     = csr_data;
            ntcmon_pkg::REG_OVER_THRESHOLD:    cfg_in.over_threshold    = csr_data;
            ntcmon_pkg::REG_RELEASE_THRESHOLD: cfg_in.release_threshold = csr_data;
            ntcmon_pkg::REG_VIRTUAL_MODE:      cfg_in.virtual_mode      = csr_data[0];
            ntcmon_pkg::REG_EXPECTED_CELSIUS:  cfg_in.expected_celsius  = csr_data;
            ntcmon_pkg::REG_DIGITAL_OFFSET:    cfg_in.digital_offset    = csr_data;
            ntcmon_pkg::REG_SENSITIVITY:       cfg_in.sensitivity       = csr_data;
            ntcmon_pkg::REG_CELSIUS_OFFSET:    cfg_in.celsius_offset    = csr_data;
            default:                           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.filter_length     <= 16'd16;
         cfg_ff.over_threshold    <= 16'hFFFF;
         cfg_ff.release_threshold <= 16'd0;
         cfg_ff.virtual_mode      <= 1'b0;
         cfg_ff.expected_celsius  <= 16'sd25;
         cfg_ff.digital_offset    <= 16'd0;
         cfg_ff.sensitivity       <= 16'sd0;
         cfg_ff.celsius_offset    <= 16'sd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- hdl/ntcmon_ctrl.sv -----
`timescale 1ns / 1ps
// sequencer of the monitor: multiply, divide, evaluate and hand off one item
// depends on ntcmon_pkg
module ntcmon_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  ntcmon_pkg::sts_type sts,
   output ntcmon_pkg::cmd_type cmd
);

   ntcmon_pkg::ctrl_state_type state_ff, state_in;
   logic accept;

   assign accept = req_tvalid && (state_ff == ntcmon_pkg::ST_IDLE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ntcmon_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               if (sts.virtual_mode)        state_in = ntcmon_pkg::ST_DONE;
               else if (sts.sample_invalid) state_in = ntcmon_pkg::ST_EVAL;
               else                         state_in = ntcmon_pkg::ST_MUL;
            end
         end
         ntcmon_pkg::ST_MUL:  state_in = ntcmon_pkg::ST_ACC;
         ntcmon_pkg::ST_ACC:  state_in = ntcmon_pkg::ST_DIV;
         ntcmon_pkg::ST_DIV: begin
            if (sts.div_last) state_in = ntcmon_pkg::ST_EVAL;
         end
         ntcmon_pkg::ST_EVAL: state_in = ntcmon_pkg::ST_DONE;
         ntcmon_pkg::ST_DONE: begin
            if (sts.out_free) state_in = ntcmon_pkg::ST_IDLE;
         end
         default: state_in = ntcmon_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ntcmon_pkg::ST_IDLE: begin
            req_tready      = 1'b1;
            cmd.capture     = accept;
            cmd.clear_fault = accept && sts.virtual_mode;
         end
         ntcmon_pkg::ST_MUL:  cmd.mul_acc  = 1'b1;
         ntcmon_pkg::ST_ACC:  cmd.load_div = 1'b1;
         ntcmon_pkg::ST_DIV:  cmd.div_step = 1'b1;
         ntcmon_pkg::ST_EVAL: cmd.eval     = 1'b1;
         ntcmon_pkg::ST_DONE: cmd.load_out = sts.out_free;
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ntcmon_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hdl/ntcmon_dpath.sv -----
`timescale 1ns / 1ps
// datapath of the monitor: shared multiplier, restoring divider, fault flag,
// celsius scaling and the output register; depends on ntcmon_pkg
module ntcmon_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ntcmon_pkg::cfg_type                  cfg,
   input  ntcmon_pkg::cmd_type                  cmd,
   output ntcmon_pkg::sts_type                  sts,
   input  logic [ntcmon_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [ntcmon_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   localparam int DW = ntcmon_pkg::DATA_WIDTH;
   localparam int SW = ntcmon_pkg::SAMPLE_WIDTH;
   localparam int MW = ntcmon_pkg::MUL_W;
   localparam int PW = ntcmon_pkg::PROD_W;

   logic [SW-1:0]        sample_ff;
   logic [DW-1:0]        avg_ff, avg_in;
   logic                 fault_ff, fault_in;
   logic signed [PW-1:0] prod_ff;
   logic [DW-1:0]        rem_ff, quo_ff;
   logic [ntcmon_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic                 out_valid_ff;
   logic [ntcmon_pkg::RSP_TDATA_W-1:0] out_data_ff;

   logic [SW-1:0]        sample_in;
   logic [DW-1:0]        n_eff;
   logic signed [MW-1:0] mul_a, mul_b;
   logic signed [PW-1:0] mul_p;
   logic [2*DW-1:0]      acc;
   logic [DW:0]          div_cat;
   logic                 div_ge;
   logic [DW-1:0]        rem_in, quo_in;
   logic signed [PW-1:0] biased;
   logic signed [PW-1:0] scaled;
   logic [DW-1:0]        cel_real, cel;

   assign sample_in = req_tdata[SW-1:0];
   assign n_eff     = (cfg.filter_length == '0) ? DW'(1) : cfg.filter_length;

   // one signed multiplier serves both the filter and the celsius scaling
   always_comb begin
      if (cmd.eval) begin
         mul_a = MW'($signed({1'b0, avg_ff}) - $signed({1'b0, cfg.digital_offset}));
         mul_b = MW'(cfg.sensitivity);
      end else begin
         mul_a = $signed({2'b00, n_eff - DW'(1)});
         mul_b = $signed({2'b00, avg_ff});
      end
      mul_p = mul_a * mul_b;
   end

   assign acc = prod_ff[2*DW-1:0] + {{(2*DW-SW){1'b0}}, sample_ff};

   // restoring step, remainder always stays below n
   assign div_cat = {rem_ff, quo_ff[DW-1]};
   assign div_ge  = div_cat >= {1'b0, n_eff};
   always_comb begin
      rem_in = div_ge ? DW'(div_cat - {1'b0, n_eff}) : div_cat[DW-1:0];
      quo_in = {quo_ff[DW-2:0], div_ge};
   end

   always_comb begin
      avg_in   = avg_ff;
      fault_in = fault_ff;
      if (cmd.div_step && (cnt_ff == ntcmon_pkg::DIV_CNT_W'(ntcmon_pkg::DIV_STEPS - 1)))
         avg_in = quo_in;
      if (cmd.clear_fault) begin
         fault_in = 1'b0;
      end else if (cmd.eval) begin
         if (avg_ff > cfg.over_threshold)         fault_in = 1'b1;
         else if (avg_ff < cfg.release_threshold) fault_in = 1'b0;
      end
   end

   // truncate toward zero: bias negative products before the arithmetic shift
   always_comb begin
      biased   = prod_ff + (prod_ff[PW-1] ? PW'((1 << ntcmon_pkg::SCALE_SHIFT) - 1) : PW'(0));
      scaled   = biased >>> ntcmon_pkg::SCALE_SHIFT;
      cel_real = scaled[DW-1:0] + cfg.celsius_offset;
      cel      = cfg.virtual_mode ? cfg.expected_celsius : cel_real;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture)  sample_ff <= sample_in;
      if (cmd.mul_acc || cmd.eval) prod_ff <= mul_p;
      if (cmd.load_div) begin
         rem_ff <= acc[2*DW-1:DW];
         quo_ff <= acc[DW-1:0];
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (cmd.load_out) begin
         out_data_ff <= {{(ntcmon_pkg::RSP_TDATA_W - 2*DW - 1){1'b0}}, cel, avg_ff, fault_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_ff       <= '0;
         fault_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         avg_ff   <= avg_in;
         fault_ff <= fault_in;
         if (cmd.load_out)     out_valid_ff <= 1'b1;
         else if (rsp_tready)  out_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   always_comb begin
      sts.virtual_mode   = cfg.virtual_mode;
      sts.sample_invalid = &sample_in;
      sts.div_last       = (cnt_ff == ntcmon_pkg::DIV_CNT_W'(ntcmon_pkg::DIV_STEPS - 1));
      sts.out_free       = !out_valid_ff || rsp_tready;
   end

endmodule

// ----- hdl/ntc_average_overtemp_monitor_core.sv -----
`timescale 1ns / 1ps
// Temperature monitor for a slow NTC sensor. Each req beat carries one raw ADC
// sample; a sample of all ones is invalid and leaves the running average
// alone. A valid sample updates avg = ((N-1)*avg + sample)/N, then the fault
// flag sets above the over threshold and clears below the release threshold.
// Every req beat gives one rsp beat with the flag, the average and the
// average in degrees Celsius (the expected value in virtual mode). One item
// at a time: one multiply, one add, 16 restoring divide steps in a shared
// subtractor, the fault check with the scaling multiply, the output load; an
// invalid sample skips to the fault check, virtual mode clears the flag and
// skips to the output load. The next req beat is taken the cycle after the
// output load, which waits while a previous result waits on rsp_tready.
// A finished result sits in the rsp register while the next beat is taken.
// depends on ntcmon_pkg, ntcmon_csr, ntcmon_ctrl, ntcmon_dpath
module ntc_average_overtemp_monitor_core (
   input  logic                                 clock,
   input  logic                                 reset,
   // sample [15:0]
   input  logic [ntcmon_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // fault [0], average_digital [16:1], temperature_celsius [32:17], zero pad
   output logic [ntcmon_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ntcmon_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ntcmon_pkg::DATA_WIDTH-1:0]    csr_data
);

   ntcmon_pkg::cfg_type cfg;
   ntcmon_pkg::cmd_type cmd;
   ntcmon_pkg::sts_type sts;

   ntcmon_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ntcmon_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   ntcmon_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ----- sim/ntc_average_overtemp_monitor_core_test.sv -----
`timescale 1ns / 1ps
// self-checking bench for ntc_average_overtemp_monitor_core: drives sample beats
// and register writes, predicts average, fault flag and celsius per beat
// depends on ntcmon_pkg and the core rtl only
module ntc_average_overtemp_monitor_core_test;

   typedef struct {
      logic                              fault;
      logic [ntcmon_pkg::DATA_WIDTH-1:0] avg;
      logic [ntcmon_pkg::DATA_WIDTH-1:0] celsius;
   } temp_reading_type;

   class overtemp_scoreboard;
      ntcmon_pkg::cfg_type               cfg;
      logic [ntcmon_pkg::DATA_WIDTH-1:0] running_avg;
      logic                              overtemp;
      temp_reading_type                  expected_readings[$];
      int                                errors;
      int                                checked;
      int                                invalid_seen;
      int                                virtual_seen;
      int                                fault_rises;

      function new();
         cfg.filter_length     = 16'd16;
         cfg.over_threshold    = 16'hFFFF;
         cfg.release_threshold = 16'd0;
         cfg.virtual_mode      = 1'b0;
         cfg.expected_celsius  = 16'sd25;
         cfg.digital_offset    = 16'd0;
         cfg.sensitivity       = 16'sd0;
         cfg.celsius_offset    = 16'sd0;
         running_avg = '0;
         overtemp    = 1'b0;
      endfunction

      function void write_reg(ntcmon_pkg::csr_index_type idx,
                              logic [ntcmon_pkg::DATA_WIDTH-1:0] v);
         case (idx)
            ntcmon_pkg::REG_FILTER_LENGTH:     cfg.filter_length     = v;
            ntcmon_pkg::REG_OVER_THRESHOLD:    cfg.over_threshold    = v;
            ntcmon_pkg::REG_RELEASE_THRESHOLD: cfg.release_threshold = v;
            ntcmon_pkg::REG_VIRTUAL_MODE:      cfg.virtual_mode      = v[0];
            ntcmon_pkg::REG_EXPECTED_CELSIUS:  cfg.expected_celsius  = v;
            ntcmon_pkg::REG_DIGITAL_OFFSET:    cfg.digital_offset    = v;
            ntcmon_pkg::REG_SENSITIVITY:       cfg.sensitivity       = v;
            ntcmon_pkg::REG_CELSIUS_OFFSET:    cfg.celsius_offset    = v;
            default: ;
         endcase
      endfunction

      function void note_sample(logic [ntcmon_pkg::SAMPLE_WIDTH-1:0] s);
         logic [31:0]      divisor;
         logic [31:0]      acc;
         longint           avg_l;
         longint           ofs_l;
         longint           sens_l;
         longint           cofs_l;
         longint           cel;
         logic             was_set;
         temp_reading_type r;
         was_set = overtemp;
         if (cfg.virtual_mode) begin
            overtemp  = 1'b0;
            r.celsius = cfg.expected_celsius;
            virtual_seen++;
         end else begin
            if (s != {ntcmon_pkg::SAMPLE_WIDTH{1'b1}}) begin
               // zero length acts as length one
               divisor     = (cfg.filter_length == '0) ? 32'd1 : 32'(cfg.filter_length);
               acc         = (divisor - 32'd1) * 32'(running_avg) + 32'(s);
               running_avg = 16'(acc / divisor);
            end else begin
               invalid_seen++;
            end
            if (running_avg > cfg.over_threshold)
               overtemp = 1'b1;
            else if (running_avg < cfg.release_threshold)
               overtemp = 1'b0;
            avg_l  = running_avg;
            ofs_l  = cfg.digital_offset;
            sens_l = $signed(cfg.sensitivity);
            cofs_l = $signed(cfg.celsius_offset);
            // signed division truncates toward zero, sum wraps to 16 bits
            cel       = ((avg_l - ofs_l) * sens_l) / 65536 + cofs_l;
            r.celsius = cel[15:0];
         end
         if (!was_set && overtemp)
            fault_rises++;
         r.fault = overtemp;
         r.avg   = running_avg;
         expected_readings.push_back(r);
      endfunction

      task report(string what);
         errors++;
         if (errors <= 30)
            $display("mismatch at %0t: %s", $time, what);
      endtask

      task check_result(logic [ntcmon_pkg::RSP_TDATA_W-1:0] beat);
         temp_reading_type want;
         if (expected_readings.size() == 0) begin
            report($sformatf("result beat %h with nothing outstanding", beat));
            return;
         end
         want = expected_readings.pop_front();
         checked++;
         if (beat[0] !== want.fault)
            report($sformatf("fault %b, expected %b", beat[0], want.fault));
         if (beat[16:1] !== want.avg)
            report($sformatf("average %0d, expected %0d", beat[16:1], want.avg));
         if (beat[32:17] !== want.celsius)
            report($sformatf("celsius %0d, expected %0d",
                             $signed(beat[32:17]), $signed(want.celsius)));
         if (beat[ntcmon_pkg::RSP_TDATA_W-1:33] !== '0)
            report($sformatf("pad bits %h not zero", beat[ntcmon_pkg::RSP_TDATA_W-1:33]));
      endtask

      function int pending();
         return expected_readings.size();
      endfunction
   endclass

   logic                                 clock;
   logic                                 reset;
   logic [ntcmon_pkg::REQ_TDATA_W-1:0]   req_tdata;
   logic                                 req_tvalid;
   logic                                 req_tready;
   logic [ntcmon_pkg::RSP_TDATA_W-1:0]   rsp_tdata;
   logic                                 rsp_tvalid;
   logic                                 rsp_tready;
   logic                                 csr_valid;
   logic                                 csr_ready;
   ntcmon_pkg::csr_index_type            csr_index;
   logic [ntcmon_pkg::DATA_WIDTH-1:0]    csr_data;

   overtemp_scoreboard sb;
   bit steady;        // no idling on either side
   bit hold_request;  // asks the receiver for one long hold-off
   int drift_level;
   int settings_used;

   ntc_average_overtemp_monitor_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("timeout at %0t", $time);
      $display("FAIL");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            sb.write_reg(csr_index, csr_data);
         if (req_tvalid && req_tready)
            sb.note_sample(req_tdata);
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata);
      end
   end

   function int gap_len();
      int r;
      r = $urandom_range(99);
      if (steady || r < 55)
         return 0;
      else if (r < 92)
         return $urandom_range(1, 4);
      return $urandom_range(10, 40);
   endfunction

   // receiver side, one assignment per pass
   initial begin
      int len;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            len = 400;
         end else if (steady) begin
            rsp_tready <= 1'b1;
            len = 1;
         end else if ($urandom_range(2) == 0) begin
            rsp_tready <= 1'b0;
            len = gap_len();
            if (len == 0)
               len = 1;
         end else begin
            rsp_tready <= 1'b1;
            len = $urandom_range(1, 20);
         end
         repeat (len) @(posedge clock);
      end
   end

   task send_sample(logic [ntcmon_pkg::SAMPLE_WIDTH-1:0] s);
      int n;
      req_tdata  <= s;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      n = gap_len();
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // csr_valid stays high across back-to-back writes; end_writes lowers it
   task set_reg(ntcmon_pkg::csr_index_type idx, logic [ntcmon_pkg::DATA_WIDTH-1:0] v);
      csr_index <= idx;
      csr_data  <= v;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task end_writes();
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // waits on the clock before checking so the beat accepted at the last edge is already noted
   task wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   function logic [ntcmon_pkg::DATA_WIDTH-1:0] pick_edge16();
      case ($urandom_range(3))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'h8000;
         default: return 16'h7FFF;
      endcase
   endfunction

   function logic [ntcmon_pkg::DATA_WIDTH-1:0] pick_wide();
      if ($urandom_range(5) == 0)
         return pick_edge16();
      return 16'($urandom);
   endfunction

   function logic [ntcmon_pkg::SAMPLE_WIDTH-1:0] pick_sample();
      int r;
      r = $urandom_range(99);
      if (r < 5)
         return 16'hFFFF;
      if (r < 9) begin
         case ($urandom_range(2))
            0:       return 16'h0000;
            1:       return 16'hFFFE;
            default: return 16'h8000;
         endcase
      end
      if (r < 50)
         return 16'($urandom);
      // slowly wandering reading, like a real sensor
      drift_level = drift_level + int'($urandom_range(2000)) - 1000;
      if (drift_level < 0)
         drift_level = 0;
      if (drift_level > 65534)
         drift_level = 65534;
      return 16'(drift_level);
   endfunction

   task random_settings();
      logic [ntcmon_pkg::DATA_WIDTH-1:0] v;
      logic [ntcmon_pkg::DATA_WIDTH-1:0] over;
      int                                r;
      for (int i = 0; i < 8; i++) begin
         if (i == int'(ntcmon_pkg::REG_VIRTUAL_MODE) || $urandom_range(3) != 0) begin
            case (ntcmon_pkg::csr_index_type'(i))
               ntcmon_pkg::REG_FILTER_LENGTH: begin
                  r = $urandom_range(99);
                  if (r < 15)
                     v = 16'($urandom_range(1));
                  else if (r < 65)
                     v = 16'($urandom_range(2, 32));
                  else if (r < 78)
                     v = 16'hFFFF;
                  else
                     v = 16'($urandom);
               end
               ntcmon_pkg::REG_OVER_THRESHOLD: begin
                  v = pick_wide();
               end
               ntcmon_pkg::REG_RELEASE_THRESHOLD: begin
                  over = sb.cfg.over_threshold;
                  v = ($urandom_range(7) == 0) ? pick_wide() : 16'($urandom_range(over));
               end
               ntcmon_pkg::REG_VIRTUAL_MODE: begin
                  v    = 16'($urandom);
                  v[0] = ($urandom_range(6) == 0);
               end
               default: v = pick_wide();
            endcase
            set_reg(ntcmon_pkg::csr_index_type'(i), v);
         end
      end
      end_writes();
   endtask

   initial begin
      sb = new();
      reset      <= 1'b1;
      req_tdata  <= '0;
      req_tvalid <= 1'b0;
      csr_valid  <= 1'b0;
      csr_index  <= ntcmon_pkg::REG_FILTER_LENGTH;
      csr_data   <= '0;
      steady       = 1'b0;
      hold_request = 1'b0;
      drift_level  = 30000;
      settings_used = 1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // power-up settings: invalid sample and top of range
      send_sample(16'h0000);
      send_sample(16'hFFFF);
      send_sample(16'hFFFE);
      send_sample(16'h1234);
      wait_idle();

      // no filtering, hysteresis band 500..1000: set, hold, clear, invalid re-check
      set_reg(ntcmon_pkg::REG_FILTER_LENGTH, 16'd1);
      set_reg(ntcmon_pkg::REG_OVER_THRESHOLD, 16'd1000);
      set_reg(ntcmon_pkg::REG_RELEASE_THRESHOLD, 16'd500);
      set_reg(ntcmon_pkg::REG_SENSITIVITY, 16'h7FFF);
      end_writes();
      send_sample(16'd2000);
      send_sample(16'd700);
      send_sample(16'd400);
      send_sample(16'hFFFF);
      send_sample(16'd1200);
      send_sample(16'hFFFF);
      wait_idle();

      // zero length, most negative scale, full offsets
      set_reg(ntcmon_pkg::REG_FILTER_LENGTH, 16'd0);
      set_reg(ntcmon_pkg::REG_SENSITIVITY, 16'h8000);
      set_reg(ntcmon_pkg::REG_DIGITAL_OFFSET, 16'hFFFF);
      set_reg(ntcmon_pkg::REG_CELSIUS_OFFSET, 16'h7FFF);
      set_reg(ntcmon_pkg::REG_OVER_THRESHOLD, 16'hFFFF);
      set_reg(ntcmon_pkg::REG_RELEASE_THRESHOLD, 16'hFFFF);
      end_writes();
      send_sample(16'h0000);
      send_sample(16'hFFFE);
      send_sample(16'd1234);
      wait_idle();

      // virtual sensor at both celsius extremes
      set_reg(ntcmon_pkg::REG_VIRTUAL_MODE, 16'h0001);
      set_reg(ntcmon_pkg::REG_EXPECTED_CELSIUS, 16'h8000);
      end_writes();
      send_sample(16'($urandom));
      send_sample(16'hFFFF);
      send_sample(16'h0000);
      wait_idle();
      set_reg(ntcmon_pkg::REG_EXPECTED_CELSIUS, 16'h7FFF);
      end_writes();
      send_sample(16'hFFFE);
      wait_idle();

      // back to real mode through bit 0 only, slowest filter
      set_reg(ntcmon_pkg::REG_VIRTUAL_MODE, 16'hFFFE);
      set_reg(ntcmon_pkg::REG_FILTER_LENGTH, 16'hFFFF);
      set_reg(ntcmon_pkg::REG_OVER_THRESHOLD, 16'h0000);
      set_reg(ntcmon_pkg::REG_RELEASE_THRESHOLD, 16'h0000);
      set_reg(ntcmon_pkg::REG_SENSITIVITY, 16'h0001);
      set_reg(ntcmon_pkg::REG_DIGITAL_OFFSET, 16'h0000);
      set_reg(ntcmon_pkg::REG_CELSIUS_OFFSET, 16'h8000);
      end_writes();
      send_sample(16'hFFFE);
      send_sample(16'hFFFE);
      send_sample(16'h0000);
      wait_idle();

      for (int phase = 0; phase < 14; phase++) begin
         steady = (phase % 5 == 3);
         random_settings();
         if (phase == 2)
            hold_request = 1'b1;
         for (int i = 0; i < 125; i++)
            send_sample(pick_sample());
         wait_idle();
      end
      steady = 1'b0;

      repeat (40) @(posedge clock);
      if (sb.pending() != 0)
         sb.report($sformatf("%0d readings never arrived", sb.pending()));
      $display("checked %0d readings over %0d register settings", sb.checked, settings_used);
      $display("%0d invalid samples, %0d in virtual mode, %0d fault rises",
               sb.invalid_seen, sb.virtual_seen, sb.fault_rises);
      if (sb.errors == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches", sb.errors);
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ----- ntc_average_overtemp_monitor_core.f -----
hdl/ntcmon_pkg.sv
hdl/ntcmon_csr.sv
hdl/ntcmon_ctrl.sv
hdl/ntcmon_dpath.sv
hdl/ntc_average_overtemp_monitor_core.sv
sim/ntc_average_overtemp_monitor_core_test.sv
